// ===== rtl/ltrem_pkg.sv =====
// ----------------------------------------------------------------------------
// ltrem_pkg
// Shared types, constants and the quarter-wave sine table for the LFO tremolo.
// ----------------------------------------------------------------------------
package ltrem_pkg;

   // Sample and table sizing
   localparam int SAMPLE_WIDTH     = 24;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);

   // Q1.16 LFO, depth and gain values
   localparam int               LFO_W    = 17;
   localparam logic [LFO_W-1:0] ONE_Q16  = 17'd65536;
   localparam logic [LFO_W-1:0] HALF_Q16 = 17'd32768;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = (SAMPLE_WIDTH > LFO_W ? SAMPLE_WIDTH : LFO_W) + 1;
   localparam int MUL_B_W = LFO_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register file
   localparam int               CSR_IDX_W     = 2;
   localparam int               CSR_DATA_W    = 32;
   localparam int               INC_W         = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVEFORM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT = 2'd2;
   localparam logic [LFO_W-1:0] DEPTH_RESET   = 17'd32768;
   localparam logic [INC_W-1:0] INC_RESET     = 31'd97391;

   typedef enum logic [1:0] {
      WAVE_TRIANGLE = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SLOPED   = 2'd2,
      WAVE_SINE     = 2'd3
   } wave_type;

   // Payloads
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_sample;
      logic signed [SAMPLE_WIDTH-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_out;
      logic signed [SAMPLE_WIDTH-1:0] right_out;
   } rsp_type;

   // One queued frame: samples plus the LFO value of its phase
   typedef struct packed {
      req_type          samples;
      logic [LFO_W-1:0] lfo;
   } item_type;

   // Quarter-wave sine table, Q1.15
   typedef logic [15:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // One Taylor term: term * x^2 / ((2n)(2n+1)), all in Q2.30
   function automatic logic [63:0] taylor_term(input logic [63:0] term,
                                               input logic [63:0] x2,
                                               input int          n);
      logic [63:0] t;
      t = (term * x2) >> 30;
      case (n)
         1:       taylor_term = t / 6;
         2:       taylor_term = t / 20;
         3:       taylor_term = t / 42;
         4:       taylor_term = t / 72;
         5:       taylor_term = t / 110;
         6:       taylor_term = t / 156;
         7:       taylor_term = t / 210;
         8:       taylor_term = t / 272;
         default: taylor_term = t / 342;
      endcase
   endfunction

   function automatic logic [15:0] quarter_sine_q15(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      x    = (64'(k) * PI_HALF_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 9; n++) begin
         term = taylor_term(term, x2, n);
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      quarter_sine_q15 = r[15:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         rom[k] = quarter_sine_q15(k);
      end
      build_sine_rom = rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/lfo_tremolo.sv =====
// ----------------------------------------------------------------------------
// lfo_tremolo
// Stereo tremolo: both samples are scaled by 1 - depth * lfo, where the LFO
// is a triangle, square, sloped square or quarter-wave sine of a 32-bit phase.
// ----------------------------------------------------------------------------
// In steady state, the back end pops a frame
// from the queue and then uses its single multiplier three times (gain, left
// sample, right sample). The front end computes the LFO value in the cycle a
// request is accepted and stores it with the samples in a two-entry queue, so
// while a result waits on rsp_stall up to three more frames are taken in (one
// in the back end, two in the queue) before req_stall rises.
// Register writes are always accepted (csr_ready is tied high) and are meant
// for times when no frame is in flight; writes to index 3 are ignored.
module lfo_tremolo import ltrem_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   wave_type         waveform_ff;
   logic [LFO_W-1:0] depth_ff;
   logic [INC_W-1:0] increment_ff;

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     queue_empty;
   item_type pop_item;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff  <= WAVE_SQUARE;
         depth_ff     <= DEPTH_RESET;
         increment_ff <= INC_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WAVEFORM:  waveform_ff  <= wave_type'(csr_data[1:0]);
            CSR_DEPTH:     depth_ff     <= csr_data[LFO_W-1:0];
            CSR_INCREMENT: increment_ff <= csr_data[INC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ltrem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .waveform   (waveform_ff),
      .increment  (increment_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   ltrem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   ltrem_back u_back (
      .clock       (clock),
      .reset       (reset),
      .depth       (depth_ff),
      .queue_empty (queue_empty),
      .queue_item  (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/ltrem_front.sv =====
// ----------------------------------------------------------------------------
// ltrem_front
// Accepts stereo frames, forms the LFO value from the current phase and
// advances the phase accumulator.
// ----------------------------------------------------------------------------
module ltrem_front import ltrem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  wave_type         waveform,
   input  logic [INC_W-1:0] increment,
   input  logic             queue_full,
   output logic             push,
   output item_type         push_item
);

   localparam int          IDX_PROD_W = 30 + SINE_IDX_W;
   localparam logic [37:0] P50_FALL   = 38'd24 << 32;
   localparam logic [37:0] P50_RISE   = 38'd49 << 32;

   logic [31:0]           phase_ff;
   logic [31:0]           phase_in;
   logic [37:0]           p50;
   logic [IDX_PROD_W-1:0] idx_prod;
   logic [SINE_IDX_W-1:0] idx;
   logic [SINE_IDX_W-1:0] rom_addr;
   logic [15:0]           sine_q15;
   logic [LFO_W-1:0]      lfo;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // LFO value of the phase before the update
   always_comb begin
      p50      = ({6'd0, phase_ff} << 5) + ({6'd0, phase_ff} << 4) + ({6'd0, phase_ff} << 1);
      idx_prod = IDX_PROD_W'(phase_ff[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
      idx      = idx_prod[IDX_PROD_W-1:30];
      rom_addr = phase_ff[30] ? SINE_IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
      sine_q15 = SINE_ROM[rom_addr];
      case (waveform)
         WAVE_TRIANGLE: begin
            if (phase_ff < 32'h4000_0000) begin
               lfo = HALF_Q16 + LFO_W'(phase_ff >> 15);
            end else if (phase_ff < 32'hC000_0000) begin
               lfo = ONE_Q16 - LFO_W'((phase_ff - 32'h4000_0000) >> 15);
            end else begin
               lfo = LFO_W'((phase_ff - 32'hC000_0000) >> 15);
            end
         end
         WAVE_SQUARE: begin
            lfo = phase_ff[31] ? '0 : ONE_Q16;
         end
         WAVE_SLOPED: begin
            if (p50 < P50_FALL) begin
               lfo = ONE_Q16;
            end else if (!phase_ff[31]) begin
               lfo = ONE_Q16 - LFO_W'((p50 - P50_FALL) >> 16);
            end else if (p50 < P50_RISE) begin
               lfo = '0;
            end else begin
               lfo = LFO_W'((p50 - P50_RISE) >> 16);
            end
         end
         default: begin
            lfo = phase_ff[31] ? HALF_Q16 - LFO_W'(sine_q15) : HALF_Q16 + LFO_W'(sine_q15);
         end
      endcase
   end

   assign push_item = '{samples: req_data, lfo: lfo};
   assign phase_in  = push ? phase_ff + {1'b0, increment} : phase_ff;

   // Phase accumulator, wraps modulo one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== rtl/ltrem_queue.sv =====
// ----------------------------------------------------------------------------
// ltrem_queue
// Short FIFO that decouples the front end from the multiply back end.
// ----------------------------------------------------------------------------
module ltrem_queue import ltrem_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/ltrem_back.sv =====
// ----------------------------------------------------------------------------
// ltrem_back
// Computes the gain and scales both samples on one shared multiplier, then
// holds the result in the output register.
// ----------------------------------------------------------------------------
module ltrem_back import ltrem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [LFO_W-1:0] depth,
   input  logic             queue_empty,
   input  item_type         queue_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GAIN,
      ST_LEFT,
      ST_RIGHT
   } state_type;

   state_type                      state_ff;
   item_type                       item_ff;
   logic [LFO_W-1:0]               gain_ff;
   logic signed [SAMPLE_WIDTH-1:0] left_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_data_ff;

   logic [LFO_W-1:0]         depth_sat;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      out_free;

   assign depth_sat = (depth > ONE_Q16) ? ONE_Q16 : depth;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_GAIN: begin
            mul_a = MUL_A_W'(depth_sat);
            mul_b = MUL_B_W'(item_ff.lfo);
         end
         ST_LEFT: begin
            mul_a = MUL_A_W'(item_ff.samples.left_sample);
            mul_b = MUL_B_W'(gain_ff);
         end
         default: begin
            mul_a = MUL_A_W'(item_ff.samples.right_sample);
            mul_b = MUL_B_W'(gain_ff);
         end
      endcase
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Sequencer: pop, gain, left, right
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output valid: set on a new result, cleared once taken
         if ((state_ff == ST_RIGHT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  item_ff  <= queue_item;
                  state_ff <= ST_GAIN;
               end
            end
            ST_GAIN: begin
               gain_ff  <= ONE_Q16 - prod[16 +: LFO_W];
               state_ff <= ST_LEFT;
            end
            ST_LEFT: begin
               left_ff  <= prod[16 +: SAMPLE_WIDTH];
               state_ff <= ST_RIGHT;
            end
            ST_RIGHT: begin
               // wait here until the output register is free
               if (out_free) begin
                  rsp_data_ff.left_out  <= left_ff;
                  rsp_data_ff.right_out <= prod[16 +: SAMPLE_WIDTH];
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sim/tb_lfo_tremolo.sv =====
// ----------------------------------------------------------------------------
// tb_lfo_tremolo
// Self-checking bench for the stereo LFO tremolo. A predictor class keeps its
// own phase, shape, depth and sine table. It works out each scaled frame when
// the request is accepted and compares responses in order, field by field.
// Directed frames cover the sample extremes, every shape, full and over-full
// depth, phase wrap, masked register bits and the unused register index.
// Random phases follow, with random idles on both sides, one stretch without
// idles and one long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
import ltrem_pkg::*;

class tremolo_checker;
   wave_type                 wave;
   logic [LFO_W-1:0]         depth;
   logic [INC_W-1:0]         step;
   logic [31:0]              phase;
   logic [15:0]              quarter_sine [0:SINE_TABLE_DEPTH];
   rsp_type                  expected_frames [$];
   int                       errors;

   function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      // quarter-wave table: Taylor series in Q2.30, rounded to Q1.15
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (64'(k) * 64'd1686629713) / 64'(SINE_TABLE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         r = (sum + 64'd16384) >> 15;
         if (r > 64'd32768) begin
            r = 64'd32768;
         end
         quarter_sine[k] = 16'(r);
      end
      wave   = WAVE_SQUARE;
      depth  = DEPTH_RESET;
      step   = INC_RESET;
      phase  = '0;
      errors = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_WAVEFORM:  wave  = wave_type'(value[1:0]);
         CSR_DEPTH:     depth = value[LFO_W-1:0];
         CSR_INCREMENT: step  = value[INC_W-1:0];
         default: ;
      endcase
   endfunction

   // LFO level in Q1.16 for the current shape
   function logic [LFO_W-1:0] lfo_level(logic [31:0] ph);
      logic [63:0]      p50;
      logic [7:0]       idx;
      logic [LFO_W-1:0] s;
      logic [LFO_W-1:0] level;
      p50 = 64'd50 * 64'(ph);
      case (wave)
         WAVE_TRIANGLE: begin
            if (ph < 32'h4000_0000) begin
               level = HALF_Q16 + 17'(ph >> 15);
            end else if (ph < 32'hC000_0000) begin
               level = ONE_Q16 - 17'((ph - 32'h4000_0000) >> 15);
            end else begin
               level = 17'((ph - 32'hC000_0000) >> 15);
            end
         end
         WAVE_SQUARE: level = (ph < 32'h8000_0000) ? ONE_Q16 : '0;
         WAVE_SLOPED: begin
            // ramps start at 0.48 and 0.98 of a cycle, slope 50
            if (p50 < (64'd24 << 32)) begin
               level = ONE_Q16;
            end else if (ph < 32'h8000_0000) begin
               level = ONE_Q16 - 17'((p50 - (64'd24 << 32)) >> 16);
            end else if (p50 < (64'd49 << 32)) begin
               level = '0;
            end else begin
               level = 17'((p50 - (64'd49 << 32)) >> 16);
            end
         end
         default: begin
            // quadrant from the top bits, table index from the next eight
            idx   = ph[29:22];
            s     = ph[30] ? 17'(quarter_sine[SINE_TABLE_DEPTH - idx])
                           : 17'(quarter_sine[idx]);
            level = ph[31] ? HALF_Q16 - s : HALF_Q16 + s;
         end
      endcase
      return level;
   endfunction

   function logic signed [SAMPLE_WIDTH-1:0] apply_gain(logic signed [SAMPLE_WIDTH-1:0] smp,
                                                       logic [LFO_W-1:0] gain);
      logic signed [47:0] prod;
      prod = 48'(smp) * $signed({1'b0, gain});
      return SAMPLE_WIDTH'(prod >>> 16);
   endfunction

   function void note_request(req_type frame);
      logic [LFO_W-1:0] full_depth;
      logic [63:0]      cut;
      logic [LFO_W-1:0] gain;
      rsp_type          scaled;
      full_depth = (depth > ONE_Q16) ? ONE_Q16 : depth;
      cut        = (64'(full_depth) * 64'(lfo_level(phase))) >> 16;
      gain       = ONE_Q16 - 17'(cut);
      scaled.left_out  = apply_gain(frame.left_sample, gain);
      scaled.right_out = apply_gain(frame.right_sample, gain);
      expected_frames.push_back(scaled);
      phase = phase + 32'(step);
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (expected_frames.size() == 0) begin
         $error("response with none pending: left %0d right %0d",
                got.left_out, got.right_out);
         errors++;
         return;
      end
      want = expected_frames.pop_front();
      if (got.left_out !== want.left_out) begin
         $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
         errors++;
      end
      if (got.right_out !== want.right_out) begin
         $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
         errors++;
      end
   endfunction

   function int pending();
      return expected_frames.size();
   endfunction
endclass

module tb_lfo_tremolo;

   localparam int                       CYCLE_LIMIT   = 200000;
   localparam int                       HOLD_CYCLES   = 300;
   localparam int                       HOLD_AT       = 400;
   localparam logic [CSR_IDX_W-1:0]     CSR_UNUSED    = 2'd3;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 24'sh800000;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 24'sh7FFFFF;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   tremolo_checker sb;
   bit             calm;
   int             cycles;
   int             frames_out;
   int             hold_left;
   bit             hold_done;

   lfo_tremolo u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: check, then pick next stall (one long hold-off)
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_data);
            frames_out++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && frames_out >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 34);
         end
      end
   end

   // one request, with random idles ahead of it; valid stays high afterwards
   task automatic send_frame(input logic signed [SAMPLE_WIDTH-1:0] left,
                             input logic signed [SAMPLE_WIDTH-1:0] right);
      req_type frame;
      frame.left_sample  = left;
      frame.right_sample = right;
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frame;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_request(frame);
   endtask

   // stop requesting and wait for every pending response
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      sb.set_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2:       return '0;
         3:       return -24'sd1;
         default: return SAMPLE_WIDTH'($urandom());
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] value;
      int                    count;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: square, half depth
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame('0, -24'sd1);
      send_frame(24'sd1, 24'sh123456);

      // triangle at full depth, quarter-cycle steps through every region
      drain();
      write_reg(CSR_WAVEFORM, 32'(WAVE_TRIANGLE));
      write_reg(CSR_DEPTH, 32'(ONE_Q16));
      write_reg(CSR_INCREMENT, 32'h4000_0000);
      repeat (5) send_frame(SAMPLE_MAX, SAMPLE_MIN);

      // sloped square; junk in upper bits, depth above full, largest step
      drain();
      write_reg(CSR_WAVEFORM, 32'hFFFF_FFFE);
      write_reg(CSR_DEPTH, 32'h0001_FFFF);
      write_reg(CSR_INCREMENT, 32'hFFFF_FFFF);
      repeat (6) send_frame(SAMPLE_MIN, SAMPLE_MAX);

      // sine; unused index must leave everything alone
      drain();
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      write_reg(CSR_WAVEFORM, 32'(WAVE_SINE));
      write_reg(CSR_DEPTH, 32'(ONE_Q16));
      write_reg(CSR_INCREMENT, 32'h0A00_0000);
      repeat (5) send_frame(SAMPLE_MAX, -24'sd1);

      // zero depth: unity gain
      drain();
      write_reg(CSR_DEPTH, '0);
      repeat (3) send_frame(SAMPLE_MIN, SAMPLE_MAX);

      // random phases, each with its own settings
      for (int p = 0; p < 19; p++) begin
         drain();
         calm = (p == 6);
         write_reg(CSR_WAVEFORM, $urandom());
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(4))
               0:       value = '0;
               1:       value = 32'(ONE_Q16);
               2:       value = $urandom();
               default: value = $urandom_range(65536);
            endcase
            write_reg(CSR_DEPTH, value);
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(5))
               0:       value = '0;
               1:       value = 32'h7FFF_FFFF;
               2:       value = 32'hFFFF_FFFF;
               3:       value = $urandom_range(65536);
               default: value = $urandom();
            endcase
            write_reg(CSR_INCREMENT, value);
         end
         if ($urandom_range(4) == 0) begin
            write_reg(CSR_UNUSED, $urandom());
         end
         count = $urandom_range(140, 60);
         repeat (count) send_frame(random_sample(), random_sample());
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
